// ----- src/sfr_pkg.sv -----
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants for the stuffed frame receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

	localparam int unsigned MAX_PAYLOAD = 1024;
	localparam int unsigned COUNT_W     = 11;

	localparam logic [7:0] FLAG_BYTE = 8'h5c;
	localparam logic [7:0] ESC_BYTE  = 8'h5d;
	localparam logic [7:0] ESC_FLAG  = 8'h7c;
	localparam logic [7:0] ESC_ESC   = 8'h7d;

	localparam logic [7:0] ADDRESS_RESET = 8'h01;
	localparam logic [7:0] CONTROL_RESET = 8'h08;

	localparam int unsigned PADDR_W = 3;
	localparam logic        REG_ADDRESS = 1'b0;
	localparam logic        REG_CONTROL = 1'b1;

	typedef enum logic [2:0] {
		HDR_HUNT = 3'd0,
		HDR_FLAG = 3'd1,
		HDR_ADDR = 3'd2,
		HDR_CTRL = 3'd3,
		HDR_DATA = 3'd4
	} hdr_state_t;

	typedef enum logic [2:0] {
		STAT_OK     = 3'd0,
		STAT_CHECK  = 3'd1,
		STAT_ESCAPE = 3'd2,
		STAT_LONG   = 3'd3,
		STAT_EMPTY  = 3'd4
	} frame_status_t;

	typedef struct packed {
		logic [7:0] address;
		logic [7:0] control;
	} sfr_cfg_t;

	typedef struct packed {
		logic          valid;
		logic [7:0]    payload_byte;
		logic          frame_end;
		frame_status_t frame_status;
	} sfr_result_t;

endpackage

// ----- src/stuffed_frame_receiver.sv -----
// ----------------------------------------------------------------------------
// stuffed_frame_receiver
// Deframer for byte-stuffed frames with address/control header and XOR check.
// ----------------------------------------------------------------------------
// One raw line byte is taken per word on the rx channel, one every clock when
// the result side keeps up. A byte sits in the input register, is decoded
// there against the frame state, and any result lands in the output register.
// The block hunts for flag 0x5c, then needs the configured address, the
// configured control and their XOR. Payload escapes 5d 7c and 5d 7d decode to
// 5c and 5d. Each payload byte comes out one byte late, as the last byte
// before the closing flag is the frame check (XOR of all payload bytes). A
// word with frame_end set closes the frame: status 0 ok, 1 check mismatch,
// 2 bad escape, 3 longer than 1024 payload bytes, 4 empty. Header bytes and
// escape bytes give no result. Registers: 0x0 expected address (reset 0x01),
// 0x4 expected control (reset 0x08); write them only while the block is idle.
// ----------------------------------------------------------------------------
module stuffed_frame_receiver (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [sfr_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	// received bytes
	input  logic                         rx_valid,
	output logic                         rx_ready,
	input  logic [7:0]                   rx_byte,
	// results
	output logic                         res_valid,
	input  logic                         res_ready,
	output logic [7:0]                   payload_byte,
	output logic                         frame_end,
	output logic [2:0]                   frame_status
);

	sfr_pkg::sfr_cfg_t    cfg;
	sfr_pkg::sfr_result_t res;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;

	logic       res_valid_q;
	logic [7:0] payload_q;
	logic       end_q;
	logic [2:0] status_q;

	sfr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// the decoded byte moves on whenever the result slot is free or emptying
	assign advance  = valid_s1 && (!res_valid_q || res_ready);
	assign rx_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (rx_ready)
			valid_s1 <= rx_valid;
	end

	always_ff @(posedge clk) begin
		if (rx_ready && rx_valid)
			byte_s1 <= rx_byte;
	end

	sfr_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.rx_byte (byte_s1),
		.cfg     (cfg),
		.res     (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (advance)
			res_valid_q <= res.valid;
		else if (res_ready)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			payload_q <= res.payload_byte;
			end_q     <= res.frame_end;
			status_q  <= res.frame_status;
		end
	end

	assign res_valid    = res_valid_q;
	assign payload_byte = payload_q;
	assign frame_end    = end_q;
	assign frame_status = status_q;

endmodule

// ----- src/sfr_regs.sv -----
// ----------------------------------------------------------------------------
// sfr_regs
// APB register file: expected address and control bytes.
// ----------------------------------------------------------------------------
module sfr_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sfr_pkg::PADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	output sfr_pkg::sfr_cfg_t             cfg
);

	logic [7:0] address_q;
	logic [7:0] control_q;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			address_q <= sfr_pkg::ADDRESS_RESET;
			control_q <= sfr_pkg::CONTROL_RESET;
		end else if (wr_en) begin
			case (paddr[2])
				sfr_pkg::REG_ADDRESS: address_q <= pwdata[7:0];
				sfr_pkg::REG_CONTROL: control_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			sfr_pkg::REG_ADDRESS: prdata = {24'd0, address_q};
			sfr_pkg::REG_CONTROL: prdata = {24'd0, control_q};
			default:              prdata = 32'd0;
		endcase
	end

	assign cfg.address = address_q;
	assign cfg.control = control_q;

endmodule

// ----- src/sfr_core.sv -----
// ----------------------------------------------------------------------------
// sfr_core
// Header check, destuffing and frame check for one byte per cycle while step is high.
// ----------------------------------------------------------------------------
module sfr_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [7:0]            rx_byte,
	input  sfr_pkg::sfr_cfg_t     cfg,
	output sfr_pkg::sfr_result_t  res
);

	sfr_pkg::hdr_state_t          state_q, state_d;
	logic                         escape_q, escape_d;
	logic [7:0]                   check_q, check_d;
	logic [7:0]                   held_q, held_d;
	logic                         held_valid_q, held_valid_d;
	logic [sfr_pkg::COUNT_W-1:0]  count_q, count_d;

	logic                         do_take;
	logic [7:0]                   take_byte;
	logic                         do_status;
	sfr_pkg::frame_status_t       status_code;
	sfr_pkg::hdr_state_t          status_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= sfr_pkg::HDR_HUNT;
			escape_q     <= 1'b0;
			check_q      <= 8'd0;
			held_q       <= 8'd0;
			held_valid_q <= 1'b0;
			count_q      <= '0;
		end else if (step) begin
			state_q      <= state_d;
			escape_q     <= escape_d;
			check_q      <= check_d;
			held_q       <= held_d;
			held_valid_q <= held_valid_d;
			count_q      <= count_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		escape_d     = escape_q;
		check_d      = check_q;
		held_d       = held_q;
		held_valid_d = held_valid_q;
		count_d      = count_q;
		do_take      = 1'b0;
		take_byte    = rx_byte;
		do_status    = 1'b0;
		status_code  = sfr_pkg::STAT_OK;
		status_next  = sfr_pkg::HDR_HUNT;
		res          = '{valid: 1'b0, payload_byte: 8'd0, frame_end: 1'b0,
			frame_status: sfr_pkg::STAT_OK};

		case (state_q)
			sfr_pkg::HDR_FLAG: begin
				if (rx_byte == sfr_pkg::FLAG_BYTE)
					state_d = sfr_pkg::HDR_FLAG;
				else if (rx_byte == cfg.address)
					state_d = sfr_pkg::HDR_ADDR;
				else
					state_d = sfr_pkg::HDR_HUNT;
			end
			sfr_pkg::HDR_ADDR: begin
				if (rx_byte == cfg.control)
					state_d = sfr_pkg::HDR_CTRL;
				else if (rx_byte == sfr_pkg::FLAG_BYTE)
					state_d = sfr_pkg::HDR_FLAG;
				else
					state_d = sfr_pkg::HDR_HUNT;
			end
			sfr_pkg::HDR_CTRL: begin
				if (rx_byte == (cfg.address ^ cfg.control)) begin
					state_d      = sfr_pkg::HDR_DATA;
					escape_d     = 1'b0;
					check_d      = 8'd0;
					held_d       = 8'd0;
					held_valid_d = 1'b0;
					count_d      = '0;
				end else if (rx_byte == sfr_pkg::FLAG_BYTE) begin
					state_d = sfr_pkg::HDR_FLAG;
				end else begin
					state_d = sfr_pkg::HDR_HUNT;
				end
			end
			sfr_pkg::HDR_DATA: begin
				if (escape_q) begin
					escape_d = 1'b0;
					if (rx_byte == sfr_pkg::ESC_FLAG) begin
						do_take   = 1'b1;
						take_byte = sfr_pkg::FLAG_BYTE;
					end else if (rx_byte == sfr_pkg::ESC_ESC) begin
						do_take   = 1'b1;
						take_byte = sfr_pkg::ESC_BYTE;
					end else begin
						do_status   = 1'b1;
						status_code = sfr_pkg::STAT_ESCAPE;
						status_next = (rx_byte == sfr_pkg::FLAG_BYTE) ?
							sfr_pkg::HDR_FLAG : sfr_pkg::HDR_HUNT;
					end
				end else if (rx_byte == sfr_pkg::ESC_BYTE) begin
					escape_d = 1'b1;
				end else if (rx_byte == sfr_pkg::FLAG_BYTE) begin
					do_status   = 1'b1;
					status_next = sfr_pkg::HDR_FLAG;
					if (!held_valid_q)
						status_code = sfr_pkg::STAT_EMPTY;
					else if (held_q == check_q)
						status_code = sfr_pkg::STAT_OK;
					else
						status_code = sfr_pkg::STAT_CHECK;
				end else begin
					do_take = 1'b1;
				end
			end
			default: begin
				state_d = (rx_byte == sfr_pkg::FLAG_BYTE) ?
					sfr_pkg::HDR_FLAG : sfr_pkg::HDR_HUNT;
			end
		endcase

		// held byte goes out only when the next data byte arrives
		if (do_take) begin
			if (held_valid_q &&
				count_q >= sfr_pkg::COUNT_W'(sfr_pkg::MAX_PAYLOAD)) begin
				do_status   = 1'b1;
				status_code = sfr_pkg::STAT_LONG;
				status_next = sfr_pkg::HDR_HUNT;
			end else begin
				if (held_valid_q) begin
					res.valid        = 1'b1;
					res.payload_byte = held_q;
					check_d          = check_q ^ held_q;
					count_d          = count_q + 1'b1;
				end
				held_d       = take_byte;
				held_valid_d = 1'b1;
			end
		end

		if (do_status) begin
			res.valid        = 1'b1;
			res.payload_byte = 8'd0;
			res.frame_end    = 1'b1;
			res.frame_status = status_code;
			state_d          = status_next;
			escape_d         = 1'b0;
			check_d          = 8'd0;
			held_d           = 8'd0;
			held_valid_d     = 1'b0;
			count_d          = '0;
		end
	end

	a_escape_in_data: assert property (@(posedge clk) disable iff (!arst_n)
		escape_q |-> state_q == sfr_pkg::HDR_DATA)
		else $error("escape pending outside payload");

	a_count_needs_held: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != '0 |-> held_valid_q)
		else $error("payload counted with no byte held");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= sfr_pkg::COUNT_W'(sfr_pkg::MAX_PAYLOAD))
		else $error("payload count beyond limit");

	a_end_zero_byte: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.valid && res.frame_end |-> res.payload_byte == 8'd0)
		else $error("status result carries payload data");

endmodule
